/* sv/sfla_pkg.sv */
// sfla_pkg: shared sizes, action and status codes for the slot free list allocator
// used by the channel interfaces and the top level; depends on nothing
package sfla_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_BITS   = 4;
  localparam int LINK_BITS   = 5;
  localparam int COUNT_BITS  = 5;
  localparam int HANDLE_BITS = 32;
  localparam int RANK_BITS   = 4;

  // link value one past the last slot ends the free list
  localparam logic [LINK_BITS-1:0] END_MARK = LINK_BITS'(SLOTS);

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SET_ON = 3'd3,
    ACT_NTH    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_NO_RANK = 2'd3
  } status_e;

endpackage

/* sv/sfla_if.sv */
// sfla_if: valid/ready channel interfaces for allocator requests and results
// depends on sfla_pkg for the field widths
interface sfla_req_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          action;
  logic [sfla_pkg::SLOT_BITS-1:0]      slot_id;
  logic [sfla_pkg::HANDLE_BITS-1:0]    handle;
  logic                                on_value;
  logic [sfla_pkg::RANK_BITS-1:0]      rank;

  modport source (output valid, action, slot_id, handle, on_value, rank, input ready);
  modport sink   (input valid, action, slot_id, handle, on_value, rank, output ready);
endinterface

interface sfla_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [sfla_pkg::SLOT_BITS-1:0]      result_slot;
  logic [sfla_pkg::HANDLE_BITS-1:0]    result_handle;
  logic                                result_on;
  logic [sfla_pkg::COUNT_BITS-1:0]     occupied_count;

  modport source (output valid, status, result_slot, result_handle, result_on,
                  occupied_count, input ready);
  modport sink   (input valid, status, result_slot, result_handle, result_on,
                  occupied_count, output ready);
endinterface

/* sv/slot_free_list_allocator_top.sv */
// slot_free_list_allocator_top: slot table with a linked free list held in RAM
// depends on sfla_pkg, sfla_req_if / sfla_rsp_if and sfla_ram
//
// Usage
//   req_i carries one request (action, slot_id, handle, on_value, rank); it is
//   taken when valid and ready are high at a clock edge. rsp_o returns exactly
//   one result per request, in order, with the occupied count after the step.
//   Handles and on flags live in one RAM, the free list links in a second RAM,
//   both with a registered read port; valid bits, free head, count and a fill
//   mark (slots never handed out link to the next slot) sit in flip-flops.
//   Remove, full add, empty slot and ignored action cases go from execute
//   straight to hand off; add / get / set_on pass through a RAM read data
//   step (one RAM read round trip), and nth_lookup scans the slots from slot 0,
//   one slot per cycle. The next request can be taken in the cycle after the
//   result loads. One request is in flight at a time; ready is high only
//   while idle, so all RAM writes of a request land before the next one
//   reads. A new request is taken while a finished result still waits in the
//   output register; if the receiver stalls, the next result holds in the
//   block until the output register frees. Reset empties the table at once:
//   no clearing pass.
module slot_free_list_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfla_req_if.sink   req_i,
  sfla_rsp_if.source rsp_o
);

  localparam int SB  = sfla_pkg::SLOT_BITS;
  localparam int LB  = sfla_pkg::LINK_BITS;
  localparam int CB  = sfla_pkg::COUNT_BITS;
  localparam int HB  = sfla_pkg::HANDLE_BITS;
  localparam int RB  = sfla_pkg::RANK_BITS;
  localparam int NS  = sfla_pkg::SLOTS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [LB-1:0] free_head_q, free_head_d;
  logic [LB-1:0] fill_q, fill_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [NS-1:0] valid_q, valid_d;
  logic          virgin_q, virgin_d;
  logic [SB-1:0] scan_q, scan_d;

  // latched request payload
  logic [2:0]    act_q;
  logic [SB-1:0] id_q;
  logic [HB-1:0] hnd_q;
  logic          onv_q;
  logic [RB-1:0] rank_q, rank_d;

  // pending result
  sfla_pkg::status_e res_status_q, res_status_d;
  logic [SB-1:0]     res_slot_q, res_slot_d;
  logic [HB-1:0]     res_handle_q, res_handle_d;
  logic              res_on_q, res_on_d;

  // output register
  logic              out_valid_q, out_valid_d;
  sfla_pkg::status_e out_status_q;
  logic [SB-1:0]     out_slot_q;
  logic [HB-1:0]     out_handle_q;
  logic              out_on_q;
  logic [CB-1:0]     out_cnt_q;
  logic              out_load;

  // ram ports
  logic          lram_we, lram_re;
  logic [SB-1:0] lram_waddr, lram_raddr;
  logic [LB-1:0] lram_wdata, lram_rdata;
  logic          hram_we, hram_re;
  logic [SB-1:0] hram_waddr, hram_raddr;
  logic [HB:0]   hram_wdata, hram_rdata;

  logic accept;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // free list links
  sfla_ram #(.WIDTH(LB), .DEPTH(NS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lram_waddr),
    .wdata_i (lram_wdata),
    .re_i    (lram_re),
    .raddr_i (lram_raddr),
    .rdata_o (lram_rdata)
  );

  // handle plus on flag, on flag in the top bit
  sfla_ram #(.WIDTH(HB + 1), .DEPTH(NS)) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_waddr),
    .wdata_i (hram_wdata),
    .re_i    (hram_re),
    .raddr_i (hram_raddr),
    .rdata_o (hram_rdata)
  );

  // sequencer: execute, read data return, rank scan, hand off
  always_comb begin
    logic [SB-1:0] head_slot;
    head_slot    = free_head_q[SB-1:0];
    state_d      = state_q;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    virgin_d     = virgin_q;
    scan_d       = scan_q;
    rank_d       = rank_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_on_d     = res_on_q;
    lram_we      = 1'b0;
    lram_waddr   = id_q;
    lram_wdata   = free_head_q;
    lram_re      = 1'b0;
    lram_raddr   = head_slot;
    hram_we      = 1'b0;
    hram_waddr   = id_q;
    hram_wdata   = {onv_q, hram_rdata[HB-1:0]};
    hram_re      = 1'b0;
    hram_raddr   = id_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = sfla_pkg::STAT_OK;
        res_slot_d   = '0;
        res_handle_d = '0;
        res_on_d     = 1'b0;
        state_d      = S_DONE;
        unique case (act_q)
          sfla_pkg::ACT_ADD: begin
            if (free_head_q == sfla_pkg::END_MARK) begin
              res_status_d = sfla_pkg::STAT_FULL;
            end else begin
              // pop head: fetch its link, store handle with on set
              lram_re     = 1'b1;
              hram_we     = 1'b1;
              hram_waddr  = head_slot;
              hram_wdata  = {1'b1, hnd_q};
              valid_d[head_slot] = 1'b1;
              cnt_d       = cnt_q + CB'(1);
              res_slot_d  = head_slot;
              virgin_d    = (free_head_q >= fill_q);
              if (free_head_q >= fill_q) begin
                fill_d = free_head_q + LB'(1);
              end
              state_d     = S_RDATA;
            end
          end
          sfla_pkg::ACT_REMOVE: begin
            if (!valid_q[id_q]) begin
              res_status_d = sfla_pkg::STAT_EMPTY;
            end else begin
              // push onto the head of the free list
              lram_we         = 1'b1;
              valid_d[id_q]   = 1'b0;
              free_head_d     = {1'b0, id_q};
              cnt_d           = cnt_q - CB'(1);
            end
          end
          sfla_pkg::ACT_GET,
          sfla_pkg::ACT_SET_ON: begin
            if (!valid_q[id_q]) begin
              res_status_d = sfla_pkg::STAT_EMPTY;
            end else begin
              hram_re = 1'b1;
              state_d = S_RDATA;
            end
          end
          sfla_pkg::ACT_NTH: begin
            res_status_d = sfla_pkg::STAT_NO_RANK;
            scan_d       = '0;
            state_d      = S_SCAN;
          end
          default: begin
          end
        endcase
      end

      S_RDATA: begin
        state_d = S_DONE;
        unique case (act_q)
          sfla_pkg::ACT_ADD: begin
            // untouched slots link to the next slot
            free_head_d = virgin_q ? (free_head_q + LB'(1)) : lram_rdata;
          end
          sfla_pkg::ACT_GET: begin
            res_handle_d = hram_rdata[HB-1:0];
            res_on_d     = hram_rdata[HB];
          end
          sfla_pkg::ACT_SET_ON: begin
            hram_we = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // one slot per cycle, counting occupied slots down the rank
        if (valid_q[scan_q] && (rank_q == '0)) begin
          res_status_d = sfla_pkg::STAT_OK;
          res_slot_d   = scan_q;
          state_d      = S_DONE;
        end else begin
          if (valid_q[scan_q]) begin
            rank_d = rank_q - RB'(1);
          end
          scan_d = scan_q + SB'(1);
          if (scan_q == SB'(NS - 1)) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      virgin_q    <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      virgin_q    <= virgin_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload and rank countdown
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= req_i.action;
      id_q   <= req_i.slot_id;
      hnd_q  <= req_i.handle;
      onv_q  <= req_i.on_value;
      rank_q <= req_i.rank;
    end else begin
      rank_q <= rank_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_on_q     <= res_on_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_handle_q <= res_handle_q;
      out_on_q     <= res_on_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_slot    = out_slot_q;
  assign rsp_o.result_handle  = out_handle_q;
  assign rsp_o.result_on      = out_on_q;
  assign rsp_o.occupied_count = out_cnt_q;

  // occupied count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(valid_q))
    else $error("occupied count out of step with valid bits");

  // free list ends exactly when the table is full
  a_full_matches_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((free_head_q == sfla_pkg::END_MARK) == (cnt_q == CB'(NS))))
    else $error("free head and occupied count disagree");

  // the free head never names an occupied slot
  a_head_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && (free_head_q != sfla_pkg::END_MARK))
      |-> !valid_q[free_head_q[SB-1:0]])
    else $error("free head points at an occupied slot");

  // a result appears only when the sequencer hands one off
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result valid without a finished request");

endmodule

/* sv/sfla_ram.sv */
// sfla_ram: generic simple dual port RAM, one write and one registered read port
// no package dependencies
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrBits-1:0]      waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrBits-1:0]      raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
